/* rtl/rle_stream_product_merge_defines.svh */
// Assertion macros used by the run-length product merge core (rsp_core).
// Clocked on clk, disabled while rst is high; no other dependencies.
`ifndef RLE_STREAM_PRODUCT_MERGE_DEFINES_SVH
`define RLE_STREAM_PRODUCT_MERGE_DEFINES_SVH

// Same-cycle implication
`define RSP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define RSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/rsp_pkg.sv */
// Shared types and constants for the run-length product merge block.
// No dependencies.
`default_nettype none

package rsp_pkg;

  // Fixed field widths of the stream payloads
  localparam int CMD_BITS        = 2;
  localparam int RUN_FIELD_BITS  = 16;
  localparam int OUT_FIELD_BITS  = 32;
  localparam int S_TDATA_BITS    = 32;
  localparam int M_TDATA_BITS    = 72;

  // Parameter defaults
  localparam int VALUE_BITS_DEF      = 16;
  localparam int LENGTH_BITS_DEF     = 16;
  localparam int OUT_LENGTH_BITS_DEF = 32;

  // Command codes
  typedef enum logic [CMD_BITS-1:0] {
    CMD_PUSH_A = 2'd0,
    CMD_PUSH_B = 2'd1,
    CMD_END    = 2'd2
  } cmd_t;

  // One input item
  typedef struct packed {
    logic [CMD_BITS-1:0]       cmd;
    logic [RUN_FIELD_BITS-1:0] run_value;
    logic [RUN_FIELD_BITS-1:0] run_length;
  } item_t;

  // One result item
  typedef struct packed {
    logic                      out_valid;
    logic [OUT_FIELD_BITS-1:0] out_value;
    logic [OUT_FIELD_BITS-1:0] out_length;
    logic                      need_a;
    logic                      need_b;
    logic                      push_error;
    logic                      last;
  } result_t;

endpackage

`default_nettype wire

/* rtl/rsp_in_reg.sv */
// Input register stage: holds one accepted item until the core consumes it.
// Depends on rsp_pkg.
`default_nettype none

module rsp_in_reg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire rsp_pkg::item_t in_item,
  input  wire logic           advance,   // core takes the held item this cycle
  output logic                held_valid,
  output rsp_pkg::item_t      held_item
);

  // Free when empty or when the held item leaves this cycle
  assign in_ready = !held_valid || advance;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_item <= in_item;
    end
  end

endmodule

`default_nettype wire

/* rtl/rsp_core.sv */
// Stream state and single-pass merge step: run bookkeeping, product, run merge.
// Depends on rsp_pkg and rle_stream_product_merge_defines.svh.
`default_nettype none
`include "rle_stream_product_merge_defines.svh"

module rsp_core #(
  parameter int VALUE_BITS      = rsp_pkg::VALUE_BITS_DEF,
  parameter int LENGTH_BITS     = rsp_pkg::LENGTH_BITS_DEF,
  parameter int OUT_LENGTH_BITS = rsp_pkg::OUT_LENGTH_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           fire,      // held item is processed this cycle
  input  wire rsp_pkg::item_t item,
  output rsp_pkg::result_t    result
);

  // Only the low bits of the 16-bit fields are significant
  localparam int VW  = (VALUE_BITS < rsp_pkg::RUN_FIELD_BITS) ?
                       VALUE_BITS : rsp_pkg::RUN_FIELD_BITS;
  localparam int LW  = (LENGTH_BITS < rsp_pkg::RUN_FIELD_BITS) ?
                       LENGTH_BITS : rsp_pkg::RUN_FIELD_BITS;
  localparam int PW  = 2 * VW;
  localparam int OLW = OUT_LENGTH_BITS;
  localparam int SW  = ((OLW > LW) ? OLW : LW) + 1;

  // Stream and pending-run state
  logic [VW-1:0]  a_value, a_value_next, b_value, b_value_next;
  logic [LW-1:0]  a_left, a_left_next, b_left, b_left_next;
  logic [PW-1:0]  pending_value, pending_value_next;
  logic [OLW-1:0] pending_length, pending_length_next;
  logic           pending_valid, pending_valid_next;

  // Step signals
  logic [VW-1:0]  in_val;
  logic [LW-1:0]  in_len;
  logic           is_end, is_push, to_a, busy, err;
  logic [VW-1:0]  a_val_mid, b_val_mid;
  logic [LW-1:0]  a_left_mid, b_left_mid, take;
  logic           step, merge, emit;
  logic [PW-1:0]  prod;
  logic [OLW-1:0] sat_base, sat_len;
  logic [SW-1:0]  sum;

  assign in_val = item.run_value[VW-1:0];
  assign in_len = item.run_length[LW-1:0];

  // Command decode and push check
  always_comb begin
    is_end  = 1'b0;
    is_push = 1'b0;
    to_a    = 1'b0;
    unique case (item.cmd)
      rsp_pkg::CMD_PUSH_A: begin
        is_push = 1'b1;
        to_a    = 1'b1;
      end
      rsp_pkg::CMD_PUSH_B: begin
        is_push = 1'b1;
      end
      rsp_pkg::CMD_END: begin
        is_end = 1'b1;
      end
      default: begin
      end
    endcase
    busy = to_a ? (a_left != '0) : (b_left != '0);
    err  = !is_end && (!is_push || busy || (in_len == '0));
  end

  // Load the pushed run, then test for a merge step
  assign a_val_mid  = (is_push && !err && to_a)  ? in_val : a_value;
  assign b_val_mid  = (is_push && !err && !to_a) ? in_val : b_value;
  assign a_left_mid = (is_push && !err && to_a)  ? in_len : a_left;
  assign b_left_mid = (is_push && !err && !to_a) ? in_len : b_left;
  assign step       = is_push && !err && (a_left_mid != '0) && (b_left_mid != '0);

  assign prod  = PW'(a_val_mid) * PW'(b_val_mid);
  assign take  = (a_left_mid < b_left_mid) ? a_left_mid : b_left_mid;
  assign merge = pending_valid && (pending_value == prod);

  // Saturating length accumulate
  assign sat_base = merge ? pending_length : '0;
  assign sum      = SW'(sat_base) + SW'(take);
  assign sat_len  = (sum > SW'({OLW{1'b1}})) ? {OLW{1'b1}} : OLW'(sum);

  assign emit = is_end ? pending_valid : (step && pending_valid && !merge);

  // Next state
  always_comb begin
    a_value_next        = a_val_mid;
    b_value_next        = b_val_mid;
    a_left_next         = a_left_mid;
    b_left_next         = b_left_mid;
    pending_value_next  = pending_value;
    pending_length_next = pending_length;
    pending_valid_next  = pending_valid;
    if (is_end) begin
      a_left_next         = '0;
      b_left_next         = '0;
      pending_value_next  = '0;
      pending_length_next = '0;
      pending_valid_next  = 1'b0;
    end else if (step) begin
      a_left_next         = a_left_mid - take;
      b_left_next         = b_left_mid - take;
      pending_value_next  = prod;
      pending_length_next = sat_len;
      pending_valid_next  = 1'b1;
    end
  end

  // Result of this step
  always_comb begin
    result.out_valid  = emit;
    result.out_value  = emit ? rsp_pkg::OUT_FIELD_BITS'(pending_value) : '0;
    result.out_length = emit ? rsp_pkg::OUT_FIELD_BITS'(pending_length) : '0;
    result.need_a     = (a_left_next == '0);
    result.need_b     = (b_left_next == '0);
    result.push_error = err;
    result.last       = is_end;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      a_value        <= '0;
      b_value        <= '0;
      a_left         <= '0;
      b_left         <= '0;
      pending_value  <= '0;
      pending_length <= '0;
      pending_valid  <= 1'b0;
    end else if (fire) begin
      a_value        <= a_value_next;
      b_value        <= b_value_next;
      a_left         <= a_left_next;
      b_left         <= b_left_next;
      pending_value  <= pending_value_next;
      pending_length <= pending_length_next;
      pending_valid  <= pending_valid_next;
    end
  end

  // Checks
  `RSP_ASSERT_NEXT(a_end_clears, fire && is_end, a_left == '0 && b_left == '0 && !pending_valid, "end left state behind")
  `RSP_ASSERT_NEXT(a_step_drains, fire && step, a_left == '0 || b_left == '0, "merge step left both streams busy")
  `RSP_ASSERT_NEXT(a_err_holds, fire && err, $stable(a_left) && $stable(b_left) && $stable(pending_length), "rejected item changed state")
  `RSP_ASSERT_SAME(a_emit_len, fire && emit, pending_length != '0, "emitted run has zero length")

endmodule

`default_nettype wire

/* rtl/rsp_out_reg.sv */
// Output register stage: holds one result until the receiver takes it.
// Depends on rsp_pkg.
`default_nettype none

module rsp_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,       // new result from the core
  input  wire rsp_pkg::result_t load_result,
  output logic                  can_load,   // register free or draining now
  output logic                  out_valid,
  input  wire logic             out_ready,
  output rsp_pkg::result_t      out_result
);

  assign can_load = !out_valid || out_ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_result <= load_result;
    end
  end

endmodule

`default_nettype wire

/* rtl/rle_stream_product_merge.sv */
// Top level of the run-length encoded elementwise product with run merging.
// Depends on rsp_pkg, rsp_in_reg, rsp_core and rsp_out_reg.
//
// Usage:
//   Slave stream: one run per transfer. s_axis_tuser selects push A, push B
//   or end; s_axis_tdata carries run value and run length.
//   Master stream: one result per input transfer. m_axis_tuser is set when
//   the result carries a finished product run; m_axis_tlast marks the result
//   of an end command. need_a/need_b tell which stream takes the next push.
//   Path: an accepted item sits in the input register, is processed by the
//   core as it is captured in the result register, and its result is offered
//   from there until the receiver takes it.
//   Throughput: one item per cycle unless the master stream stalls; the merge
//   step (one multiply of up to 16x16 bits, a compare, a saturating add) sets it.
//   Stalls: while m_axis_tready is low the result register holds, the input
//   register still takes one more item if it is empty, then s_axis_tready drops.
//   Reset (rst, synchronous): both streams empty, no pending run, both
//   register stages empty.
`default_nettype none

module rle_stream_product_merge #(
  parameter int VALUE_BITS      = rsp_pkg::VALUE_BITS_DEF,
  parameter int LENGTH_BITS     = rsp_pkg::LENGTH_BITS_DEF,
  parameter int OUT_LENGTH_BITS = rsp_pkg::OUT_LENGTH_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [15:0] run_value, [31:16] run_length
  input  wire logic [rsp_pkg::S_TDATA_BITS-1:0]  s_axis_tdata,
  // [1:0] cmd
  input  wire logic [rsp_pkg::CMD_BITS-1:0]      s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [31:0] out_value, [63:32] out_length, [64] need_a, [65] need_b,
  // [66] push_error, [71:67] zero
  output logic [rsp_pkg::M_TDATA_BITS-1:0]       m_axis_tdata,
  // [0] out_valid
  output logic                                   m_axis_tuser,
  output logic                                   m_axis_tlast
);

  rsp_pkg::item_t   in_item, held_item;
  rsp_pkg::result_t core_result, out_result;
  logic             held_valid, can_load, fire;

  // Unpack the slave transfer
  assign in_item.cmd        = s_axis_tuser;
  assign in_item.run_value  = s_axis_tdata[15:0];
  assign in_item.run_length = s_axis_tdata[31:16];

  assign fire = held_valid && can_load;

  rsp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .advance    (can_load),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  rsp_core #(
    .VALUE_BITS      (VALUE_BITS),
    .LENGTH_BITS     (LENGTH_BITS),
    .OUT_LENGTH_BITS (OUT_LENGTH_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (held_item),
    .result (core_result)
  );

  rsp_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .load        (fire),
    .load_result (core_result),
    .can_load    (can_load),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_result  (out_result)
  );

  // Pack the master transfer
  assign m_axis_tdata = {5'd0, out_result.push_error, out_result.need_b,
                         out_result.need_a, out_result.out_length,
                         out_result.out_value};
  assign m_axis_tuser = out_result.out_valid;
  assign m_axis_tlast = out_result.last;

endmodule

`default_nettype wire
